// ===== hdl/tts_pkg.sv =====
// Package for the tick trading signal engine.
// Holds the widths, the codes and the decision operand bundle.
// It depends on nothing else.
package tts_pkg;

  localparam int PRICE_BITS = 20;
  localparam int MID_BITS   = PRICE_BITS + 1;
  localparam int HIST_DEPTH = 64;
  localparam int PTR_BITS   = $clog2(HIST_DEPTH);
  localparam int CNT_BITS   = PTR_BITS + 1;
  localparam int SUM_BITS   = MID_BITS + PTR_BITS;
  localparam int THR_BITS   = 16;
  localparam int LOT_BITS   = 16;
  localparam int SCAL_BITS  = 8;
  localparam int QTY_BITS   = 24;
  localparam int SIDE_BITS  = 2;
  localparam int MODE_BITS  = 2;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 3;
  localparam int IN_BITS    = 40;
  localparam int OUT_BITS   = 48;

  localparam logic [SIDE_BITS-1:0] SIDE_HOLD = 2'd0;
  localparam logic [SIDE_BITS-1:0] SIDE_BUY  = 2'd1;
  localparam logic [SIDE_BITS-1:0] SIDE_SELL = 2'd2;

  localparam logic [MODE_BITS-1:0] MODE_MOMENTUM  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_REVERSION = 2'd1;

  localparam logic [IDX_BITS-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_LOOKBACK = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_WINDOW   = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_ENTRY    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_DEV      = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_LOT      = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_SCALAR   = 3'd6;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [MID_BITS-1:0]  mid;
    logic [MID_BITS-1:0]  past;
    logic [SUM_BITS-1:0]  sum;
    logic [CNT_BITS-1:0]  lookback;
    logic [CNT_BITS-1:0]  window;
    logic [CNT_BITS-1:0]  fill;
    logic [THR_BITS-1:0]  entry_thr;
    logic [THR_BITS-1:0]  dev_thr;
  } dec_op_t;

endpackage

// ===== hdl/tick_trading_signal_engine.sv =====
// Top level of the tick trading signal engine: sequencer, history memory,
// running window sum, configuration registers and the result register.
// Depends on tts_pkg and tts_decide.
//
//  Channel  | Direction | Signals                          | Payload
//  ---------+-----------+----------------------------------+------------------------------
//  s_*      | in        | s_tvalid, s_tready, s_tdata[39:0] | ask_price, bid_price
//  m_*      | out       | m_tvalid, m_tready, m_tdata[47:0] | side, quantity, order_price
//  cfg_*    | in        | cfg_wr_en, cfg_index, cfg_wdata  | register write, no read-back
//
// A tick runs these steps in order: accept with the first history read, a second read, the
// multiply stage, and the decide stage that writes the history and the result.
// The single read port of the history memory makes the two reads separate steps.
// After a write of window_length the next tick first resums the window from the
// memory, one entry a cycle, over min(window_length, stored ticks) entries.
// Reset needs no clearing pass. A result waits in the output register while the
// next tick is worked; the decide stage waits only while that register is full.
module tick_trading_signal_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tts_pkg::IN_BITS-1:0]   s_tdata,   // ask_price[19:0], bid_price[39:20]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tts_pkg::OUT_BITS-1:0]  m_tdata,   // side[1:0], quantity[25:2],
                                                   // order_price[45:26], zero[47:46]
  input  logic                          cfg_wr_en,
  input  logic [tts_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [tts_pkg::CFG_BITS-1:0]  cfg_wdata
);
  import tts_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_RDA   = 3'd2;
  localparam logic [2:0] ST_RDB   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DEC   = 3'd5;

  logic [2:0]            state;
  logic [MODE_BITS-1:0]  mode;
  logic [CNT_BITS-1:0]   lookback;
  logic [CNT_BITS-1:0]   window;
  logic [THR_BITS-1:0]   entry_thr;
  logic [THR_BITS-1:0]   dev_thr;
  logic [LOT_BITS-1:0]   lot_size;
  logic [SCAL_BITS-1:0]  scalar;

  logic [PTR_BITS-1:0]   wp;
  logic [CNT_BITS-1:0]   fill;
  logic [SUM_BITS-1:0]   sum;
  logic                  dirty;
  logic [CNT_BITS-1:0]   sw_cnt;
  logic                  pend;

  logic [PRICE_BITS-1:0] ask;
  logic [PRICE_BITS-1:0] bid;
  logic [MID_BITS-1:0]   mid;
  logic [MID_BITS-1:0]   past;
  logic [MID_BITS-1:0]   old;
  logic [QTY_BITS-1:0]   qty;

  logic [MID_BITS-1:0]   mem [HIST_DEPTH];
  logic [PTR_BITS-1:0]   rd_addr;
  logic [MID_BITS-1:0]   rdata;
  logic                  mem_we;

  logic [CNT_BITS-1:0]   sw_n;
  logic                  fire;
  dec_op_t               op;
  logic [SIDE_BITS-1:0]  side;
  logic [PRICE_BITS-1:0] price;

  assign s_tready = (state == ST_IDLE);
  assign fire     = (state == ST_DEC) && (!m_tvalid || m_tready);
  assign mem_we   = fire;
  assign sw_n     = (window < fill) ? window : fill;

  always_comb begin
    case (state)
      ST_SWEEP: rd_addr = wp - sw_cnt[PTR_BITS-1:0];
      ST_RDB:   rd_addr = wp - window[PTR_BITS-1:0];
      default:  rd_addr = wp - lookback[PTR_BITS-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= mid;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    op.mode      = mode;
    op.mid       = mid;
    op.past      = past;
    op.sum       = sum;
    op.lookback  = lookback;
    op.window    = window;
    op.fill      = fill;
    op.entry_thr = entry_thr;
    op.dev_thr   = dev_thr;
  end

  tts_decide u_decide (
    .clk  (clk),
    .load (state == ST_MUL),
    .op   (op),
    .side (side)
  );

  always_comb begin
    if ((mode == MODE_MOMENTUM) == (side == SIDE_BUY)) begin
      price = ask;
    end else begin
      price = bid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_MOMENTUM;
      lookback  <= CNT_BITS'(1);
      window    <= CNT_BITS'(1);
      entry_thr <= '0;
      dev_thr   <= '0;
      lot_size  <= '0;
      scalar    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODE:     mode      <= cfg_wdata[MODE_BITS-1:0];
        REG_LOOKBACK: lookback  <= cfg_wdata[CNT_BITS-1:0];
        REG_WINDOW:   window    <= cfg_wdata[CNT_BITS-1:0];
        REG_ENTRY:    entry_thr <= cfg_wdata[THR_BITS-1:0];
        REG_DEV:      dev_thr   <= cfg_wdata[THR_BITS-1:0];
        REG_LOT:      lot_size  <= cfg_wdata[LOT_BITS-1:0];
        REG_SCALAR:   scalar    <= cfg_wdata[SCAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wp       <= '0;
      fill     <= '0;
      sum      <= '0;
      dirty    <= 1'b0;
      pend     <= 1'b0;
      sw_cnt   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_WINDOW)) begin
        dirty <= 1'b1;
      end
      if (m_tvalid && m_tready && !fire) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (dirty) begin
              sum    <= '0;
              sw_cnt <= CNT_BITS'(1);
              pend   <= 1'b0;
              state  <= ST_SWEEP;
            end else begin
              state <= ST_RDB;
            end
          end
        end
        ST_SWEEP: begin
          if (sw_cnt <= sw_n) begin
            sw_cnt <= sw_cnt + CNT_BITS'(1);
            pend   <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            sum <= sum + SUM_BITS'(rdata);
          end
          if ((sw_cnt > sw_n) && !pend) begin
            dirty <= 1'b0;
            state <= ST_RDA;
          end
        end
        ST_RDA: state <= ST_RDB;
        ST_RDB: state <= ST_MUL;
        ST_MUL: state <= ST_DEC;
        ST_DEC: begin
          if (fire) begin
            m_tvalid <= 1'b1;
            wp       <= wp + PTR_BITS'(1);
            if (fill < CNT_BITS'(HIST_DEPTH)) begin
              fill <= fill + CNT_BITS'(1);
            end
            if ((window != '0) && (fill >= window)) begin
              sum <= sum + SUM_BITS'(mid) - SUM_BITS'(old);
            end else begin
              sum <= sum + SUM_BITS'(mid);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ask <= s_tdata[PRICE_BITS-1:0];
      bid <= s_tdata[2*PRICE_BITS-1:PRICE_BITS];
      mid <= {1'b0, s_tdata[PRICE_BITS-1:0]} + {1'b0, s_tdata[2*PRICE_BITS-1:PRICE_BITS]};
    end
    if (state == ST_RDB) begin
      past <= rdata;
    end
    if (state == ST_MUL) begin
      old <= rdata;
      qty <= QTY_BITS'(lot_size * scalar);
    end
    if (fire) begin
      if (side == SIDE_HOLD) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {{(OUT_BITS - SIDE_BITS - QTY_BITS - PRICE_BITS){1'b0}}, price, qty, side};
      end
    end
  end

  a_side_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[SIDE_BITS-1:0] != 2'd3))
    else $error("result side code out of range");

  a_hold_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[SIDE_BITS-1:0] == SIDE_HOLD))
      |-> (m_tdata[OUT_BITS-1:SIDE_BITS] == '0))
    else $error("hold result carries a quantity or price");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_BITS'(HIST_DEPTH))
    else $error("fill count beyond history depth");

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    fire |=> (wp == $past(wp) + PTR_BITS'(1)) && m_tvalid)
    else $error("history pointer or result not advanced on decide");

  a_dirty_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(dirty) |-> ($past(state) == ST_SWEEP) || $past(rst))
    else $error("window sum marked clean without a resum");

endmodule

// ===== hdl/tts_decide.sv =====
// Decision unit: one multiply stage and one compare stage.
// Uses tts_pkg for widths, side codes and the operand bundle.
module tts_decide (
  input  logic                          clk,
  input  logic                          load,
  input  tts_pkg::dec_op_t              op,
  output logic [tts_pkg::SIDE_BITS-1:0] side
);
  import tts_pkg::*;

  localparam int MOM_RHS_BITS = THR_BITS + MID_BITS;
  localparam int MOM_CMP_BITS = MID_BITS + 1 + 16;
  localparam int WMID_BITS    = CNT_BITS + MID_BITS;
  localparam int REV_RHS_BITS = THR_BITS + SUM_BITS;
  localparam int DEV_BITS     = WMID_BITS + 1;
  localparam int REV_CMP_BITS = DEV_BITS + 16;

  logic [MODE_BITS-1:0]        mode_q;
  logic                        mom_ok;
  logic                        rev_ok;
  logic signed [MID_BITS:0]    delta;
  logic [MOM_RHS_BITS-1:0]     mom_rhs;
  logic [WMID_BITS-1:0]        wmid;
  logic [REV_RHS_BITS-1:0]     rev_rhs;
  logic [SUM_BITS-1:0]         sum_q;

  logic signed [MOM_CMP_BITS-1:0] mom_lhs;
  logic signed [MOM_CMP_BITS-1:0] mom_r;
  logic signed [DEV_BITS-1:0]     dev;
  logic signed [REV_CMP_BITS-1:0] rev_lhs;
  logic signed [REV_CMP_BITS-1:0] rev_r;

  always_ff @(posedge clk) begin
    if (load) begin
      mode_q  <= op.mode;
      mom_ok  <= (op.lookback != '0) && (op.fill >= op.lookback) && (op.mid != '0);
      rev_ok  <= (op.window != '0) && (op.fill >= op.window) && (op.sum != '0);
      delta   <= $signed({1'b0, op.mid}) - $signed({1'b0, op.past});
      mom_rhs <= MOM_RHS_BITS'(op.entry_thr * op.mid);
      wmid    <= WMID_BITS'(op.window * op.mid);
      rev_rhs <= REV_RHS_BITS'(op.dev_thr * op.sum);
      sum_q   <= op.sum;
    end
  end

  always_comb begin
    mom_lhs = MOM_CMP_BITS'({delta, 16'd0});
    mom_r   = $signed({1'b0, mom_rhs});
    dev     = $signed({1'b0, wmid}) - $signed({{(DEV_BITS - SUM_BITS){1'b0}}, sum_q});
    rev_lhs = REV_CMP_BITS'({dev, 16'd0});
    rev_r   = $signed({{(REV_CMP_BITS - REV_RHS_BITS){1'b0}}, rev_rhs});
    side    = SIDE_HOLD;
    case (mode_q)
      MODE_MOMENTUM: begin
        if (mom_ok) begin
          if (mom_lhs >= mom_r) begin
            side = SIDE_BUY;
          end else if (mom_lhs <= -mom_r) begin
            side = SIDE_SELL;
          end
        end
      end
      MODE_REVERSION: begin
        if (rev_ok) begin
          if (rev_lhs >= rev_r) begin
            side = SIDE_SELL;
          end else if (rev_lhs <= -rev_r) begin
            side = SIDE_BUY;
          end
        end
      end
      default: side = SIDE_HOLD;
    endcase
  end

endmodule
